>>> hw/rtl/kbs_pkg.sv
`default_nettype none
package kbs_pkg;

  // shape values and basis format
  localparam int SHAPE_W    = 16;
  localparam int BASIS_W    = 20;
  localparam int BASIS_N    = 16;
  localparam int KB_W       = 50;
  localparam int STEPS_W    = 7;
  localparam int IDX_W      = 6;
  localparam int MAX_STEPS  = 64;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int NUM_LANES  = 3;

  localparam logic signed [SHAPE_W-1:0] SHAPE_ONE = 16'sd16384;

  // register map
  localparam logic [CFG_IDX_W-1:0] CFG_TENSION    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS       = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTINUITY = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEPS      = 4'd3;

  typedef logic signed [BASIS_W-1:0] bcoef_t;
  typedef bcoef_t basis_t [BASIS_N];

  // basis for zero tension, bias and continuity (Catmull-Rom), row major
  localparam basis_t BASIS_RESET = '{
    -20'sd8192,  20'sd24576, -20'sd24576,  20'sd8192,
     20'sd16384, -20'sd40960,  20'sd32768, -20'sd8192,
    -20'sd8192,  20'sd0,       20'sd8192,   20'sd0,
     20'sd0,     20'sd16384,   20'sd0,      20'sd0
  };

  typedef struct packed {
    logic signed [SHAPE_W-1:0] tension;
    logic signed [SHAPE_W-1:0] bias;
    logic signed [SHAPE_W-1:0] continuity;
  } shape_t;

  // sequencer to lanes
  typedef struct packed {
    logic             load;
    logic             mac;
    logic [1:0]       row;
    logic [1:0]       col;
    logic             init;
    logic             mul;
    logic             prep;
    logic             div;
    logic             add;
    logic [1:0]       k;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] n;
  } ctl_t;

  // sequencer to output stage
  typedef struct packed {
    logic             load;
    logic [IDX_W-1:0] idx;
    logic             last;
  } emit_t;

  function automatic logic signed [SHAPE_W-1:0] clamp_shape(input logic signed [SHAPE_W-1:0] v);
    logic signed [SHAPE_W-1:0] r;
    begin
      r = v;
      if (v > SHAPE_ONE) r = SHAPE_ONE;
      if (v < -SHAPE_ONE) r = -SHAPE_ONE;
      return r;
    end
  endfunction

  // round a Q43 basis term to Q14 and saturate to the entry width
  function automatic bcoef_t round_basis(input logic signed [KB_W-1:0] kv);
    logic signed [KB_W-1:0] rnd;
    logic signed [KB_W-1:0] sh;
    bcoef_t r;
    begin
      rnd = kv + (50'sd1 <<< 28);
      sh  = rnd >>> 29;
      if (sh[KB_W-1:BASIS_W-1] == '0 || sh[KB_W-1:BASIS_W-1] == '1) begin
        r = sh[BASIS_W-1:0];
      end else begin
        r = {sh[KB_W-1], {(BASIS_W-1){~sh[KB_W-1]}}};
      end
      return r;
    end
  endfunction

  // index of the final point, from the steps register
  function automatic logic [IDX_W-1:0] last_index(input logic [STEPS_W-1:0] s);
    logic [IDX_W-1:0] r;
    begin
      r = IDX_W'(s - 7'd1);
      if (s < 7'd2) r = 6'd1;
      if (s > 7'(MAX_STEPS)) r = IDX_W'(MAX_STEPS - 1);
      return r;
    end
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/kbs_if.sv
`default_nettype none
interface kbs_in_if #(parameter int COORD_WIDTH = 24);
  logic valid;
  logic ready;
  logic signed [COORD_WIDTH-1:0] p0_x, p0_y, p0_z;
  logic signed [COORD_WIDTH-1:0] p1_x, p1_y, p1_z;
  logic signed [COORD_WIDTH-1:0] p2_x, p2_y, p2_z;
  logic signed [COORD_WIDTH-1:0] p3_x, p3_y, p3_z;
  modport source (output valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
                  p2_x, p2_y, p2_z, p3_x, p3_y, p3_z, input ready);
  modport sink (input valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
                p2_x, p2_y, p2_z, p3_x, p3_y, p3_z, output ready);
endinterface

interface kbs_out_if #(parameter int COORD_WIDTH = 24);
  logic valid;
  logic ready;
  logic signed [COORD_WIDTH-1:0] out_x, out_y, out_z;
  logic [5:0] point_index;
  logic last;
  modport source (output valid, out_x, out_y, out_z, point_index, last, input ready);
  modport sink (input valid, out_x, out_y, out_z, point_index, last, output ready);
endinterface

interface kbs_cfg_if;
  logic valid;
  logic ready;
  logic [3:0] index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/kbs_basis.sv
`default_nettype none
module kbs_basis (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  kbs_pkg::shape_t shape,
  output logic            busy,
  output kbs_pkg::bcoef_t basis [kbs_pkg::BASIS_N]
);
  import kbs_pkg::*;

  logic signed [SHAPE_W-1:0] tc, bc, cc;
  logic signed [SHAPE_W:0] omt_s, cp_s, cm_s, bp_s, bm_s;
  logic [15:0] a_omt, a_cp, a_cm, a_bp, a_bm;
  logic [31:0] b_u1, b_u2;
  logic [15:0] b_bp, b_bm;
  logic [47:0] c_a, c_b, c_c, c_d;
  logic v_a, v_b, v_c;
  logic signed [KB_W-1:0] ea, eb, ec, ed, one;
  logic signed [KB_W-1:0] kv [BASIS_N];

  // clamp and form the one-plus / one-minus factors
  always_comb begin
    tc    = clamp_shape(shape.tension);
    bc    = clamp_shape(shape.bias);
    cc    = clamp_shape(shape.continuity);
    omt_s = 17'sd16384 - {tc[SHAPE_W-1], tc};
    cp_s  = 17'sd16384 + {cc[SHAPE_W-1], cc};
    cm_s  = 17'sd16384 - {cc[SHAPE_W-1], cc};
    bp_s  = 17'sd16384 + {bc[SHAPE_W-1], bc};
    bm_s  = 17'sd16384 - {bc[SHAPE_W-1], bc};
  end

  // basis terms from the four products
  always_comb begin
    ea  = $signed({2'b00, c_a});
    eb  = $signed({2'b00, c_b});
    ec  = $signed({2'b00, c_c});
    ed  = $signed({2'b00, c_d});
    one = 50'sd1 <<< 42;
    kv[0]  = -ea;
    kv[1]  = (one <<< 2) + ea - eb - ec;
    kv[2]  = -(one <<< 2) + eb + ec - ed;
    kv[3]  = ed;
    kv[4]  = ea <<< 1;
    kv[5]  = -(one <<< 2) - (one <<< 1) - (ea <<< 1) + (eb <<< 1) + ec;
    kv[6]  = (one <<< 2) + (one <<< 1) - (eb <<< 1) - ec + ed;
    kv[7]  = -ed;
    kv[8]  = -ea;
    kv[9]  = ea - eb;
    kv[10] = eb;
    kv[11] = '0;
    kv[12] = '0;
    kv[13] = one <<< 1;
    kv[14] = '0;
    kv[15] = '0;
  end

  assign busy = start | v_a | v_b | v_c;

  // four-stage derivation pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      v_a   <= 1'b0;
      v_b   <= 1'b0;
      v_c   <= 1'b0;
      basis <= BASIS_RESET;
    end else begin
      v_a <= start;
      v_b <= v_a;
      v_c <= v_b;
      if (v_c) begin
        for (int e = 0; e < BASIS_N; e++) basis[e] <= round_basis(kv[e]);
      end
    end
  end

  always_ff @(posedge clk) begin
    a_omt <= omt_s[15:0];
    a_cp  <= cp_s[15:0];
    a_cm  <= cm_s[15:0];
    a_bp  <= bp_s[15:0];
    a_bm  <= bm_s[15:0];
    b_u1  <= a_omt * a_cp;
    b_u2  <= a_omt * a_cm;
    b_bp  <= a_bp;
    b_bm  <= a_bm;
    c_a   <= b_u1 * b_bp;
    c_d   <= b_u1 * b_bm;
    c_b   <= b_u2 * b_bm;
    c_c   <= b_u2 * b_bp;
  end

endmodule
`default_nettype wire

>>> hw/rtl/kbs_lane.sv
`default_nettype none
module kbs_lane #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk,
  input  kbs_pkg::ctl_t                 ctl,
  input  logic signed [COORD_WIDTH-1:0] pt [4],
  input  kbs_pkg::bcoef_t               bsel,
  output logic signed [COORD_WIDTH-1:0] result
);
  import kbs_pkg::*;

  localparam int CW        = COORD_WIDTH;
  localparam int COEF_W    = CW + 8;
  localparam int HI_W      = CW - 15;
  localparam int H_W       = CW + 7;
  localparam int L_W       = 39;
  localparam int SUM_W     = CW + 18;
  localparam int PROD_W    = COEF_W + 7;
  localparam int Y_W       = COEF_W + 9;
  localparam int DIV_STEPS = (CW + 24) / 8;
  localparam int DIV_W     = DIV_STEPS * 8;
  localparam int ADD_W     = DIV_W + 2;

  logic signed [CW-1:0] p_r [4];
  logic signed [COEF_W-1:0] coef [4];
  logic signed [H_W-1:0] h_acc, h_base, h_sum;
  logic signed [L_W-1:0] l_acc, l_base, l_sum, l_rnd, l_sh;
  logic signed [CW-1:0] pj, hi_full;
  logic signed [HI_W-1:0] hi;
  logic signed [16:0] lo;
  logic signed [BASIS_W+HI_W-1:0] prod_h;
  logic signed [BASIS_W+16:0] prod_l;
  logic signed [SUM_W-1:0] c_sum;
  logic signed [COEF_W-1:0] c_sat;
  logic signed [COEF_W-1:0] acc;
  logic signed [PROD_W-1:0] prod;
  logic signed [Y_W-1:0] y;
  logic [Y_W-1:0] mag;
  logic neg;
  logic [DIV_W-1:0] dq, dq_next;
  logic [6:0] rem, rem_next;
  logic [7:0] den;
  logic signed [ADD_W-1:0] qs, a_sum;
  logic signed [COEF_W-1:0] a_sat;
  logic signed [COEF_W:0] o_rnd, o_sh;

  // coefficient multiply-accumulate on split point halves
  always_comb begin
    pj      = p_r[ctl.col];
    hi_full = pj >>> 16;
    hi      = hi_full[HI_W-1:0];
    lo      = $signed({1'b0, pj[15:0]});
    prod_h  = bsel * hi;
    prod_l  = bsel * lo;
    h_base  = (ctl.col == 2'd0) ? '0 : h_acc;
    l_base  = (ctl.col == 2'd0) ? '0 : l_acc;
    h_sum   = h_base + H_W'(prod_h);
    l_sum   = l_base + L_W'(prod_l);
    l_rnd   = l_sum + 39'sd32;
    l_sh    = l_rnd >>> 6;
    c_sum   = (SUM_W'(h_sum) <<< 10) + SUM_W'(l_sh);
    if (c_sum[SUM_W-1:COEF_W-1] == '0 || c_sum[SUM_W-1:COEF_W-1] == '1) begin
      c_sat = c_sum[COEF_W-1:0];
    end else begin
      c_sat = {c_sum[SUM_W-1], {(COEF_W-1){~c_sum[SUM_W-1]}}};
    end
  end

  // rounded divide setup: floor((2x+n)/2n) on the magnitude
  always_comb begin
    y   = (Y_W'(prod) <<< 1) + Y_W'($signed({1'b0, ctl.n}));
    den = {1'b0, ctl.n, 1'b0};
    mag = y[Y_W-1] ? (~y + Y_W'(den)) : y;
  end

  // eight quotient bits per cycle
  always_comb begin
    logic [7:0] r9;
    rem_next = rem;
    dq_next  = dq;
    for (int b = 0; b < 8; b++) begin
      r9      = {rem_next, dq_next[DIV_W-1]};
      dq_next = {dq_next[DIV_W-2:0], 1'b0};
      if (r9 >= den) begin
        r9         = r9 - den;
        dq_next[0] = 1'b1;
      end
      rem_next = r9[6:0];
    end
  end

  // Horner step: add the next coefficient and saturate
  always_comb begin
    qs    = neg ? -ADD_W'(dq) : ADD_W'(dq);
    a_sum = qs + ADD_W'(coef[ctl.k]);
    if (a_sum[ADD_W-1:COEF_W-1] == '0 || a_sum[ADD_W-1:COEF_W-1] == '1) begin
      a_sat = a_sum[COEF_W-1:0];
    end else begin
      a_sat = {a_sum[ADD_W-1], {(COEF_W-1){~a_sum[ADD_W-1]}}};
    end
  end

  // drop the extra fraction bits with rounding
  always_comb begin
    o_rnd = (COEF_W+1)'(acc) + (COEF_W+1)'(128);
    o_sh  = o_rnd >>> 8;
    if (o_sh[COEF_W:CW-1] == '0 || o_sh[COEF_W:CW-1] == '1) begin
      result = o_sh[CW-1:0];
    end else begin
      result = {o_sh[COEF_W], {(CW-1){~o_sh[COEF_W]}}};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) p_r <= pt;
    if (ctl.mac) begin
      h_acc <= h_sum;
      l_acc <= l_sum;
      if (ctl.col == 2'd3) coef[ctl.row] <= c_sat;
    end
    if (ctl.init) acc <= coef[0];
    if (ctl.mul) prod <= acc * $signed({1'b0, ctl.i});
    if (ctl.prep) begin
      neg <= y[Y_W-1];
      dq  <= DIV_W'(mag);
      rem <= '0;
    end
    if (ctl.div) begin
      dq  <= dq_next;
      rem <= rem_next;
    end
    if (ctl.add) acc <= a_sat;
  end

endmodule
`default_nettype wire

>>> hw/rtl/kbs_merge.sv
`default_nettype none
module kbs_merge #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  kbs_pkg::emit_t                emit,
  input  logic signed [COORD_WIDTH-1:0] lane_val [kbs_pkg::NUM_LANES],
  output logic                          room,
  kbs_out_if.source                     res
);
  import kbs_pkg::*;

  assign room = !res.valid || res.ready;

  // hold the point until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else begin
      if (emit.load) res.valid <= 1'b1;
      else if (res.ready) res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.load) begin
      res.out_x       <= lane_val[0];
      res.out_y       <= lane_val[1];
      res.out_z       <= lane_val[2];
      res.point_index <= emit.idx;
      res.last        <= emit.last;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/kochanek_bartels_spline_segment.sv
`default_nettype none
// Channel | Dir | Payload                                   | Transfer
// pts     | in  | p0..p3 x/y/z, signed Q15.8                | valid && ready
// res     | out | out_x/y/z, point_index, last              | valid && ready
// cfg     | in  | index (0 tension, 1 bias, 2 continuity,   | valid && ready
//         |     |   3 steps), data                          |
// One segment at a time: after the accept cycle, the coefficients are formed
// (one basis entry per cycle in all three axis lanes), then each point is
// evaluated by Horner steps, each of which uses its lane's own radix-256
// divider. A write to a shape register re-derives the basis.
// Reset is synchronous; a stall on res holds the sequencer in its emit state
// until the output register frees up.
module kochanek_bartels_spline_segment #(
  parameter int COORD_WIDTH = 24
) (
  input  logic      clk,
  input  logic      rst,
  kbs_in_if.sink    pts,
  kbs_out_if.source res,
  kbs_cfg_if.sink   cfg
);
  import kbs_pkg::*;

  localparam int DIV_STEPS = (COORD_WIDTH + 24) / 8;
  localparam logic [3:0] DIV_LAST = 4'(DIV_STEPS - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_COEF, ST_INIT, ST_MUL, ST_PREP, ST_DIV, ST_ADD, ST_EMIT
  } state_t;

  state_t state;
  logic [3:0] cnt;
  logic [1:0] k;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] n_r;
  shape_t shape;
  logic [STEPS_W-1:0] steps;
  logic derive;
  logic basis_busy;
  bcoef_t basis [BASIS_N];
  bcoef_t bsel;
  ctl_t ctl;
  emit_t emit;
  logic room;
  logic pts_xfer, cfg_xfer, shape_wr;
  logic signed [COORD_WIDTH-1:0] lane_pt [NUM_LANES][4];
  logic signed [COORD_WIDTH-1:0] lane_val [NUM_LANES];

  assign cfg.ready = 1'b1;
  assign cfg_xfer  = cfg.valid && cfg.ready;
  assign shape_wr  = cfg_xfer && (cfg.index == CFG_TENSION || cfg.index == CFG_BIAS ||
                                  cfg.index == CFG_CONTINUITY);
  assign pts.ready = (state == ST_IDLE) && !derive && !basis_busy && !cfg.valid;
  assign pts_xfer  = pts.valid && pts.ready;

  // route control points to their axis lanes
  assign lane_pt[0] = '{pts.p0_x, pts.p1_x, pts.p2_x, pts.p3_x};
  assign lane_pt[1] = '{pts.p0_y, pts.p1_y, pts.p2_y, pts.p3_y};
  assign lane_pt[2] = '{pts.p0_z, pts.p1_z, pts.p2_z, pts.p3_z};

  assign bsel = basis[cnt];

  // decode lane controls from the sequencer state
  always_comb begin
    ctl      = '0;
    ctl.load = pts_xfer;
    ctl.mac  = (state == ST_COEF);
    ctl.row  = cnt[3:2];
    ctl.col  = cnt[1:0];
    ctl.init = (state == ST_INIT);
    ctl.mul  = (state == ST_MUL);
    ctl.prep = (state == ST_PREP);
    ctl.div  = (state == ST_DIV);
    ctl.add  = (state == ST_ADD);
    ctl.k    = k;
    ctl.i    = idx;
    ctl.n    = n_r;
    emit.load = (state == ST_EMIT) && room;
    emit.idx  = idx;
    emit.last = (idx == n_r);
  end

  // sequencer and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      cnt    <= '0;
      k      <= 2'd1;
      idx    <= '0;
      n_r    <= last_index(7'd16);
      shape  <= '0;
      steps  <= 7'd16;
      derive <= 1'b0;
    end else begin
      derive <= shape_wr;
      if (cfg_xfer) begin
        case (cfg.index)
          CFG_TENSION:    shape.tension    <= cfg.data;
          CFG_BIAS:       shape.bias       <= cfg.data;
          CFG_CONTINUITY: shape.continuity <= cfg.data;
          CFG_STEPS:      steps            <= cfg.data[STEPS_W-1:0];
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (pts_xfer) begin
            state <= ST_COEF;
            cnt   <= '0;
            idx   <= '0;
            n_r   <= last_index(steps);
          end
        end
        ST_COEF: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'd15) state <= ST_INIT;
        end
        ST_INIT: begin
          k     <= 2'd1;
          state <= ST_MUL;
        end
        ST_MUL: state <= ST_PREP;
        ST_PREP: begin
          cnt   <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          cnt <= cnt + 4'd1;
          if (cnt == DIV_LAST) state <= ST_ADD;
        end
        ST_ADD: begin
          if (k == 2'd3) begin
            state <= ST_EMIT;
          end else begin
            k     <= k + 2'd1;
            state <= ST_MUL;
          end
        end
        ST_EMIT: begin
          if (room) begin
            if (idx == n_r) begin
              state <= ST_IDLE;
            end else begin
              idx   <= idx + 6'd1;
              state <= ST_INIT;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  kbs_basis u_basis (
    .clk   (clk),
    .rst   (rst),
    .start (derive),
    .shape (shape),
    .busy  (basis_busy),
    .basis (basis)
  );

  for (genvar ax = 0; ax < NUM_LANES; ax++) begin : g_lane
    kbs_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane (
      .clk    (clk),
      .ctl    (ctl),
      .pt     (lane_pt[ax]),
      .bsel   (bsel),
      .result (lane_val[ax])
    );
  end

  kbs_merge #(.COORD_WIDTH(COORD_WIDTH)) u_merge (
    .clk      (clk),
    .rst      (rst),
    .emit     (emit),
    .lane_val (lane_val),
    .room     (room),
    .res      (res)
  );

endmodule
`default_nettype wire

>>> hw/rtl/kbs_check.sv
`default_nettype none
module kbs_check #(
  parameter int COORD_WIDTH = 24
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   pts_valid,
  input logic                   pts_ready,
  input logic                   cfg_valid,
  input logic                   res_valid,
  input logic                   res_ready,
  input logic [COORD_WIDTH-1:0] res_x,
  input logic [5:0]             res_idx,
  input logic                   res_last
);

  logic [5:0] exp_idx;

  // track the index the next point must carry
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_idx <= '0;
    end else if (res_valid && res_ready) begin
      exp_idx <= res_last ? 6'd0 : exp_idx + 6'd1;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_x) && $stable(res_idx))
    else $error("stalled point changed");

  a_order: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_idx == exp_idx)
    else $error("point index out of sequence");

  a_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_last |-> res_idx != 6'd0)
    else $error("segment ended after one point");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    pts_valid && pts_ready |=> !pts_ready)
    else $error("second segment taken while busy");

  a_cfg_excl: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> !pts_ready)
    else $error("segment taken alongside a register write");

endmodule

bind kochanek_bartels_spline_segment kbs_check #(.COORD_WIDTH(COORD_WIDTH)) u_check (
  .clk       (clk),
  .rst       (rst),
  .pts_valid (pts.valid),
  .pts_ready (pts.ready),
  .cfg_valid (cfg.valid),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_x     (res.out_x),
  .res_idx   (res.point_index),
  .res_last  (res.last)
);
`default_nettype wire

>>> sim/tb_kochanek_bartels_spline_segment.sv
`default_nettype none
// Scoreboard: holds the shape and step settings, derives the basis and
// queues the expected curve points for every accepted segment.
class spline_scoreboard;
  typedef struct {
    logic signed [23:0] x, y, z;
    logic [5:0] idx;
    logic lst;
  } curve_pt_t;

  logic signed [15:0] tension, bias, continuity;
  logic [6:0] steps;
  longint basis [4][4];
  curve_pt_t pending_pts [$];
  int mismatches;

  function longint fdiv(longint x, longint d);
    longint q;
    q = x / d;
    if ((x % d) != 0 && x < 0) q--;
    return q;
  endfunction

  function longint rdiv(longint x, longint d);
    return fdiv(2 * x + d, 2 * d);
  endfunction

  function longint sat(longint v, int w);
    longint hi, lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function longint clamp(logic signed [15:0] v);
    longint r;
    r = v;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r;
  endfunction

  function void derive_basis();
    longint t, b, c, one, omt, a, bb, cc, d;
    longint k [4][4];
    t = clamp(tension); b = clamp(bias); c = clamp(continuity);
    one = longint'(1) <<< 42;
    omt = 16384 - t;
    a  = omt * (16384 + c) * (16384 + b);
    bb = omt * (16384 - c) * (16384 - b);
    cc = omt * (16384 - c) * (16384 + b);
    d  = omt * (16384 + c) * (16384 - b);
    k[0] = '{-a, 4 * one + a - bb - cc, -4 * one + bb + cc - d, d};
    k[1] = '{2 * a, -6 * one - 2 * a + 2 * bb + cc, 6 * one - 2 * bb - cc + d, -d};
    k[2] = '{-a, a - bb, bb, 0};
    k[3] = '{0, 2 * one, 0, 0};
    for (int r = 0; r < 4; r++)
      for (int j = 0; j < 4; j++)
        basis[r][j] = sat(rdiv(k[r][j], longint'(1) <<< 29), 20);
  endfunction

  function new();
    tension = 0; bias = 0; continuity = 0; steps = 16; mismatches = 0;
    derive_basis();
  endfunction

  function void write_reg(logic [3:0] idx, logic [15:0] val);
    case (idx)
      kbs_pkg::CFG_TENSION:    tension = val;
      kbs_pkg::CFG_BIAS:       bias = val;
      kbs_pkg::CFG_CONTINUITY: continuity = val;
      kbs_pkg::CFG_STEPS:      steps = val[6:0];
      default: ;
    endcase
    derive_basis();
  endfunction

  // Note an accepted segment: form coefficients, then Horner per point.
  function void note_segment(logic signed [23:0] p [4][3]);
    longint q [4][3];
    longint h, l, hi, acc, n;
    longint outv [3];
    int cnt;
    curve_pt_t e;
    for (int r = 0; r < 4; r++)
      for (int ax = 0; ax < 3; ax++) begin
        h = 0; l = 0;
        for (int j = 0; j < 4; j++) begin
          hi = fdiv(p[j][ax], 65536);
          h += basis[r][j] * hi;
          l += basis[r][j] * (p[j][ax] - hi * 65536);
        end
        q[r][ax] = sat(h * 1024 + rdiv(l, 64), 32);
      end
    cnt = steps;
    if (cnt < 2) cnt = 2;
    if (cnt > 64) cnt = 64;
    n = cnt - 1;
    for (int i = 0; i < cnt; i++) begin
      for (int ax = 0; ax < 3; ax++) begin
        acc = q[0][ax];
        for (int k2 = 1; k2 < 4; k2++)
          acc = sat(rdiv(acc * i, n) + q[k2][ax], 32);
        outv[ax] = sat(rdiv(acc, 256), 24);
      end
      e.x = outv[0]; e.y = outv[1]; e.z = outv[2];
      e.idx = i[5:0]; e.lst = (i == cnt - 1);
      pending_pts.push_back(e);
    end
  endfunction

  function void check_point(logic signed [23:0] x, y, z, logic [5:0] idx, logic lst);
    curve_pt_t e;
    if (pending_pts.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected point idx=%0d", idx);
      return;
    end
    e = pending_pts.pop_front();
    if (e.x !== x || e.y !== y || e.z !== z || e.idx !== idx || e.lst !== lst) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch exp %0d %0d %0d i%0d l%0d got %0d %0d %0d i%0d l%0d",
                 e.x, e.y, e.z, e.idx, e.lst, x, y, z, idx, lst);
    end
  endfunction
endclass

module tb_kochanek_bartels_spline_segment;
  import kbs_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  kbs_in_if #(.COORD_WIDTH(24)) pts ();
  kbs_out_if #(.COORD_WIDTH(24)) res ();
  kbs_cfg_if cfg ();

  kochanek_bartels_spline_segment #(.COORD_WIDTH(24)) DUT (
    .clk(clk), .rst(rst), .pts(pts), .res(res), .cfg(cfg)
  );

  spline_scoreboard curve_sb;
  bit stim_done = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic signed [23:0] rand_coord(int mode);
    case (mode)
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return 24'sd0;
      3: return $signed(24'($urandom_range(0, 4095)) - 24'd2048);
      default: return $signed(24'($urandom));
    endcase
  endfunction

  // Send one segment and wait for its transfer.
  task automatic send_segment(int mode);
    logic signed [23:0] p [4][3];
    int m;
    repeat (1 + gap_len()) @(posedge clk);
    for (int j = 0; j < 4; j++)
      for (int ax = 0; ax < 3; ax++) begin
        m = (mode < 0) ? $urandom_range(0, 4) : mode;
        p[j][ax] = rand_coord(m);
      end
    pts.valid <= 1'b1;
    pts.p0_x <= p[0][0]; pts.p0_y <= p[0][1]; pts.p0_z <= p[0][2];
    pts.p1_x <= p[1][0]; pts.p1_y <= p[1][1]; pts.p1_z <= p[1][2];
    pts.p2_x <= p[2][0]; pts.p2_y <= p[2][1]; pts.p2_z <= p[2][2];
    pts.p3_x <= p[3][0]; pts.p3_y <= p[3][1]; pts.p3_z <= p[3][2];
    @(posedge clk);
    while (!pts.ready) @(posedge clk);
    curve_sb.note_segment(p);
    pts.valid <= 1'b0;
  endtask

  // Write one register once the block has drained.
  task automatic write_reg(logic [3:0] idx, logic [15:0] val);
    while (curve_sb.pending_pts.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    curve_sb.write_reg(idx, val);
    cfg.valid <= 1'b0;
  endtask

  task automatic set_shape(logic [15:0] t, logic [15:0] b, logic [15:0] c, logic [15:0] s);
    write_reg(CFG_TENSION, t);
    write_reg(CFG_BIAS, b);
    write_reg(CFG_CONTINUITY, c);
    write_reg(CFG_STEPS, s);
  endtask

  function automatic logic [15:0] rand_shape();
    case ($urandom_range(0, 5))
      0: return 16'h4000;
      1: return 16'hC000;
      2: return 16'($urandom);
      default: return 16'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  // Result side: random stalls, check every transfer.
  always @(posedge clk) begin
    if (!rst && res.valid && res.ready)
      curve_sb.check_point(res.out_x, res.out_y, res.out_z, res.point_index, res.last);
  end

  initial begin
    int stall;
    res.ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = $urandom_range(0, 99) < 50 ? 0 : gap_len();
      if (stall == 0) begin
        res.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end else begin
        res.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    curve_sb = new();
    pts.valid = 1'b0;
    {pts.p0_x, pts.p0_y, pts.p0_z, pts.p1_x, pts.p1_y, pts.p1_z} = '0;
    {pts.p2_x, pts.p2_y, pts.p2_z, pts.p3_x, pts.p3_y, pts.p3_z} = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset basis, coordinate extremes, shape and step extremes.
    for (int m = 0; m < 5; m++) send_segment(m);
    set_shape(16'h4000, 16'h4000, 16'h4000, 16'd2);
    send_segment(0); send_segment(1); send_segment(-1);
    set_shape(16'hC000, 16'hC000, 16'hC000, 16'd64);
    send_segment(0); send_segment(1); send_segment(-1);
    // out-of-range shapes and steps clamp
    set_shape(16'h7FFF, 16'h8000, 16'h5000, 16'd0);
    send_segment(-1); send_segment(4);
    set_shape(16'h8000, 16'h7FFF, 16'hB000, 16'd1);
    send_segment(-1);
    set_shape(16'h0000, 16'h0000, 16'h0000, 16'd127);
    send_segment(-1);
    write_reg(4'd9, 16'hFFFF);
    write_reg(CFG_STEPS, 16'hFF85);
    send_segment(2); send_segment(-1);

    // Random phases with fresh settings.
    for (int ph = 0; ph < 14; ph++) begin
      set_shape(rand_shape(), rand_shape(), rand_shape(),
                (ph % 5 == 0) ? 16'($urandom_range(33, 64)) : 16'($urandom_range(2, 12)));
      for (int n = 0; n < 21; n++) send_segment(-1);
    end
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (curve_sb.pending_pts.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (curve_sb.mismatches == 0 && curve_sb.pending_pts.size() == 0)
      $display("tb_kochanek_bartels_spline_segment OK");
    else
      $display("tb_kochanek_bartels_spline_segment NOT OK");
    $finish;
  end

  initial begin
    #100000000;
    $display("tb_kochanek_bartels_spline_segment NOT OK");
    $finish;
  end
endmodule
`default_nettype wire
